### hdl/tneq_pkg.sv
package tneq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int MAX_BLOCK   = 4096;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int OFFSET_W    = 15;
   localparam int FRAME_W     = 13;
   localparam int VEL_W       = 7;
   localparam int CODE_W      = 4;
   localparam int NUM_VOICES  = 8;

   localparam logic [CODE_W-1:0] PANIC_CODE = 4'd8;
   localparam logic [3:0]        STATUS_CONTROL = 4'hb;
   localparam logic [3:0]        STATUS_NOTE_ON = 4'h9;
   localparam logic [7:0]        CC_ALL_SOUND_OFF = 8'd120;
   localparam logic [7:0]        CC_ALL_NOTES_OFF = 8'd123;
   localparam logic [1:0]        FULL_LENGTH = 2'd3;

   localparam logic [7:0] DRUM_NOTES [NUM_VOICES] = '{
      8'd36, 8'd38, 8'd39, 8'd42, 8'd46, 8'd45, 8'd37, 8'd56
   };

   typedef enum logic [1:0] {
      KIND_MIDI  = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_BLOCK = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      RPT_QUEUED   = 3'd0,
      RPT_IGNORED  = 3'd1,
      RPT_DROPPED  = 3'd2,
      RPT_FLUSHED  = 3'd3,
      RPT_RELEASED = 3'd4,
      RPT_DONE     = 3'd5
   } report_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_READ,
      ST_INS_EVAL,
      ST_TICK_READ,
      ST_TICK_EVAL,
      ST_BLK_READ,
      ST_BLK_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [CODE_W-1:0]   code;
      logic [VEL_W-1:0]    velocity;
   } entry_type;

   typedef struct packed {
      logic       found;
      logic [2:0] voice;
   } voice_hit_type;

   function automatic voice_hit_type lookup_voice(input logic [7:0] note);
      voice_hit_type hit;
      hit = '0;
      for (int v = NUM_VOICES - 1; v >= 0; v--) begin
         if (note == DRUM_NOTES[v]) begin
            hit.found = 1'b1;
            hit.voice = 3'(v);
         end
      end
      return hit;
   endfunction

endpackage

### hdl/tneq_req_if.sv
interface tneq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  status_byte;
   logic [7:0]  data_one;
   logic [7:0]  data_two;
   logic [1:0]  msg_length;
   logic signed [15:0] event_offset;
   logic [12:0] frame_value;

   modport source (
      output valid, kind, status_byte, data_one, data_two, msg_length,
             event_offset, frame_value,
      input  ready
   );
   modport sink (
      input  valid, kind, status_byte, data_one, data_two, msg_length,
             event_offset, frame_value,
      output ready
   );
endinterface

interface tneq_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] report;
   logic       is_panic;
   logic [2:0] voice;
   logic [6:0] velocity;
   logic [6:0] queue_count;
   logic       last;

   modport source (
      output valid, report, is_panic, voice, velocity, queue_count, last,
      input  ready
   );
   modport sink (
      input  valid, report, is_panic, voice, velocity, queue_count, last,
      output ready
   );
endinterface

### hdl/timestamped_note_event_queue.sv
// Steps: an ignored or dropped midi message goes straight to its result; a queued one moves
// past each pending entry with a later offset, one read and one write each; a tick reads and
// releases each due event in turn; block end reads and rewrites each pending entry.
// One item is handled at a time, set by the single read and single write port of the
// entry memory.
// Reset (synchronous): queue empty, no result pending; entry memory is not cleared.
module timestamped_note_event_queue (
   input  logic              clock,
   input  logic              reset,
   tneq_req_if.sink          req_bus,
   tneq_rsp_if.source        rsp_bus
);

   localparam int CW = tneq_pkg::CNT_W;
   localparam int IW = tneq_pkg::IDX_W;
   localparam int FW = tneq_pkg::FRAME_W;
   localparam int OW = tneq_pkg::OFFSET_W;

   tneq_pkg::entry_type queue_mem [tneq_pkg::QUEUE_DEPTH];

   tneq_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        held_ff, held_in;
   logic [CW-1:0]        rel_ff, rel_in;
   logic [CW-1:0]        at_ff, at_in;
   logic [CW-1:0]        wr_ff, wr_in;
   tneq_pkg::entry_type  new_ff, new_in;
   logic [FW-1:0]        frame_ff, frame_in;
   tneq_pkg::report_type rep_ff, rep_in;
   tneq_pkg::entry_type  pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   tneq_pkg::entry_type  rd_data_ff;

   logic                 mem_we;
   logic [IW-1:0]        mem_wa;
   tneq_pkg::entry_type  mem_wd;
   logic [IW-1:0]        mem_rd_addr;

   logic                 rsp_valid_ff, rsp_valid_in;
   tneq_pkg::report_type rsp_report_ff, rsp_report_in;
   logic                 rsp_panic_ff, rsp_panic_in;
   logic [2:0]           rsp_voice_ff, rsp_voice_in;
   logic [6:0]           rsp_vel_ff, rsp_vel_in;
   logic [6:0]           rsp_count_ff, rsp_count_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 emit;
   tneq_pkg::report_type emit_report;
   logic                 emit_panic;
   logic [2:0]           emit_voice;
   logic [6:0]           emit_vel;
   logic                 emit_last;

   logic                  accept, slot, full, due, shift, ins_more, blk_more;
   logic                  msg_len_ok, msg_panic, msg_note;
   tneq_pkg::voice_hit_type hit;
   logic [OW-1:0]         clamp_offset;
   logic [FW-1:0]         clamp_frames;
   logic [OW-1:0]         frames_wide;
   logic [OW-1:0]         adj_offset;
   logic [CW-1:0]         at_m1;
   tneq_pkg::kind_type    req_kind;

   assign req_kind     = tneq_pkg::kind_type'(req_bus.kind);
   assign req_bus.ready = (state_ff == tneq_pkg::ST_IDLE);
   assign accept       = req_bus.valid && req_bus.ready;
   assign slot         = !rsp_valid_ff || rsp_bus.ready;
   assign full         = held_ff >= CW'(tneq_pkg::QUEUE_DEPTH);

   assign hit          = tneq_pkg::lookup_voice(req_bus.data_one);
   assign msg_len_ok   = (req_bus.msg_length == tneq_pkg::FULL_LENGTH);
   assign msg_panic    = msg_len_ok && (req_bus.status_byte[7:4] == tneq_pkg::STATUS_CONTROL)
                         && (req_bus.data_one == tneq_pkg::CC_ALL_SOUND_OFF ||
                             req_bus.data_one == tneq_pkg::CC_ALL_NOTES_OFF);
   assign msg_note     = msg_len_ok && (req_bus.status_byte[7:4] == tneq_pkg::STATUS_NOTE_ON)
                         && !req_bus.data_two[7] && (req_bus.data_two != 8'd0) && hit.found;
   assign clamp_offset = req_bus.event_offset[15] ? '0 : req_bus.event_offset[OW-1:0];
   assign clamp_frames = (32'(req_bus.frame_value) > tneq_pkg::MAX_BLOCK) ?
                         FW'(tneq_pkg::MAX_BLOCK) : req_bus.frame_value;

   assign at_m1        = at_ff - CW'(1);
   assign ins_more     = at_ff > rel_ff;
   assign shift        = rd_data_ff.offset > new_ff.offset;
   assign due          = (rel_ff < held_ff) && (rd_data_ff.offset <= OW'(frame_ff));
   assign blk_more     = at_ff < held_ff;
   assign frames_wide  = OW'(frame_ff);
   assign adj_offset   = (rd_data_ff.offset > frames_wide) ?
                         rd_data_ff.offset - frames_wide : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tneq_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  tneq_pkg::KIND_MIDI: begin
                     if (!msg_panic && !msg_note) state_in = tneq_pkg::ST_FINISH;
                     else if (full && !msg_panic) state_in = tneq_pkg::ST_FINISH;
                     else state_in = tneq_pkg::ST_INS_READ;
                  end
                  tneq_pkg::KIND_TICK: state_in = tneq_pkg::ST_TICK_READ;
                  tneq_pkg::KIND_BLOCK: begin
                     if (req_bus.frame_value == '0) state_in = tneq_pkg::ST_FINISH;
                     else state_in = tneq_pkg::ST_BLK_READ;
                  end
                  tneq_pkg::KIND_CLEAR: state_in = tneq_pkg::ST_FINISH;
               endcase
            end
         end
         tneq_pkg::ST_INS_READ:
            state_in = ins_more ? tneq_pkg::ST_INS_EVAL : tneq_pkg::ST_FINISH;
         tneq_pkg::ST_INS_EVAL:
            state_in = shift ? tneq_pkg::ST_INS_READ : tneq_pkg::ST_FINISH;
         tneq_pkg::ST_TICK_READ: state_in = tneq_pkg::ST_TICK_EVAL;
         tneq_pkg::ST_TICK_EVAL: begin
            if (pend_valid_ff || !due) begin
               if (slot) state_in = due ? tneq_pkg::ST_TICK_READ : tneq_pkg::ST_IDLE;
            end else begin
               state_in = tneq_pkg::ST_TICK_READ;
            end
         end
         tneq_pkg::ST_BLK_READ:
            state_in = blk_more ? tneq_pkg::ST_BLK_WRITE : tneq_pkg::ST_FINISH;
         tneq_pkg::ST_BLK_WRITE: state_in = tneq_pkg::ST_BLK_READ;
         tneq_pkg::ST_FINISH: begin
            if (slot) state_in = tneq_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      held_in       = held_ff;
      rel_in        = rel_ff;
      at_in         = at_ff;
      wr_in         = wr_ff;
      new_in        = new_ff;
      frame_in      = frame_ff;
      rep_in        = rep_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      mem_we        = 1'b0;
      mem_wa        = at_ff[IW-1:0];
      mem_wd        = new_ff;
      mem_rd_addr   = rel_ff[IW-1:0];
      emit          = 1'b0;
      emit_report   = tneq_pkg::RPT_DONE;
      emit_panic    = 1'b0;
      emit_voice    = '0;
      emit_vel      = '0;
      emit_last     = 1'b1;
      unique case (state_ff)
         tneq_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  tneq_pkg::KIND_MIDI: begin
                     new_in.offset   = clamp_offset;
                     new_in.code     = msg_panic ? tneq_pkg::PANIC_CODE : {1'b0, hit.voice};
                     new_in.velocity = msg_panic ? '0 : req_bus.data_two[6:0];
                     if (!msg_panic && !msg_note) begin
                        rep_in = tneq_pkg::RPT_IGNORED;
                     end else if (full) begin
                        if (!msg_panic) begin
                           rep_in = tneq_pkg::RPT_DROPPED;
                        end else begin
                           held_in = '0;
                           rel_in  = '0;
                           at_in   = '0;
                           rep_in  = tneq_pkg::RPT_FLUSHED;
                        end
                     end else begin
                        at_in  = held_ff;
                        rep_in = tneq_pkg::RPT_QUEUED;
                     end
                  end
                  tneq_pkg::KIND_TICK: begin
                     frame_in      = req_bus.frame_value;
                     pend_valid_in = 1'b0;
                  end
                  tneq_pkg::KIND_BLOCK: begin
                     frame_in = clamp_frames;
                     at_in    = rel_ff;
                     wr_in    = '0;
                     rep_in   = tneq_pkg::RPT_DONE;
                  end
                  tneq_pkg::KIND_CLEAR: begin
                     held_in = '0;
                     rel_in  = '0;
                     rep_in  = tneq_pkg::RPT_DONE;
                  end
               endcase
            end
         end
         tneq_pkg::ST_INS_READ: begin
            mem_rd_addr = at_m1[IW-1:0];
            if (!ins_more) begin
               mem_we  = 1'b1;
               held_in = held_ff + CW'(1);
            end
         end
         tneq_pkg::ST_INS_EVAL: begin
            mem_we = 1'b1;
            if (shift) begin
               mem_wd = rd_data_ff;
               at_in  = at_m1;
            end else begin
               held_in = held_ff + CW'(1);
            end
         end
         tneq_pkg::ST_TICK_READ: begin
         end
         tneq_pkg::ST_TICK_EVAL: begin
            if (pend_valid_ff || !due) begin
               if (slot) begin
                  emit = 1'b1;
                  if (pend_valid_ff) begin
                     emit_report = tneq_pkg::RPT_RELEASED;
                     emit_last   = !due;
                     if (pend_ff.code == tneq_pkg::PANIC_CODE) begin
                        emit_panic = 1'b1;
                     end else begin
                        emit_voice = pend_ff.code[2:0];
                        emit_vel   = pend_ff.velocity;
                     end
                  end
                  if (due) begin
                     pend_in       = rd_data_ff;
                     pend_valid_in = 1'b1;
                     rel_in        = rel_ff + CW'(1);
                  end
               end
            end else begin
               pend_in       = rd_data_ff;
               pend_valid_in = 1'b1;
               rel_in        = rel_ff + CW'(1);
            end
         end
         tneq_pkg::ST_BLK_READ: begin
            mem_rd_addr = at_ff[IW-1:0];
            if (!blk_more) begin
               held_in = wr_ff;
               rel_in  = '0;
            end
         end
         tneq_pkg::ST_BLK_WRITE: begin
            mem_we        = 1'b1;
            mem_wa        = wr_ff[IW-1:0];
            mem_wd        = rd_data_ff;
            mem_wd.offset = adj_offset;
            wr_in         = wr_ff + CW'(1);
            at_in         = at_ff + CW'(1);
         end
         tneq_pkg::ST_FINISH: begin
            if (slot) begin
               emit        = 1'b1;
               emit_report = rep_ff;
               if (rep_ff == tneq_pkg::RPT_QUEUED || rep_ff == tneq_pkg::RPT_FLUSHED) begin
                  if (new_ff.code == tneq_pkg::PANIC_CODE) begin
                     emit_panic = 1'b1;
                  end else begin
                     emit_voice = new_ff.code[2:0];
                     emit_vel   = new_ff.velocity;
                  end
               end
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = emit ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
      rsp_report_in = emit ? emit_report : rsp_report_ff;
      rsp_panic_in  = emit ? emit_panic : rsp_panic_ff;
      rsp_voice_in  = emit ? emit_voice : rsp_voice_ff;
      rsp_vel_in    = emit ? emit_vel : rsp_vel_ff;
      rsp_count_in  = emit ? 7'(held_ff - rel_ff) : rsp_count_ff;
      rsp_last_in   = emit ? emit_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) queue_mem[mem_wa] <= mem_wd;
      rd_data_ff <= queue_mem[mem_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tneq_pkg::ST_IDLE;
         held_ff       <= '0;
         rel_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         rel_ff        <= rel_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      at_ff         <= at_in;
      wr_ff         <= wr_in;
      new_ff        <= new_in;
      frame_ff      <= frame_in;
      rep_ff        <= rep_in;
      pend_ff       <= pend_in;
      rsp_report_ff <= rsp_report_in;
      rsp_panic_ff  <= rsp_panic_in;
      rsp_voice_ff  <= rsp_voice_in;
      rsp_vel_ff    <= rsp_vel_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.report      = rsp_report_ff;
   assign rsp_bus.is_panic    = rsp_panic_ff;
   assign rsp_bus.voice       = rsp_voice_ff;
   assign rsp_bus.velocity    = rsp_vel_ff;
   assign rsp_bus.queue_count = rsp_count_ff;
   assign rsp_bus.last        = rsp_last_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CW'(tneq_pkg::QUEUE_DEPTH))
      else $error("held count above queue depth");

   a_rel_le_held: assert property (@(posedge clock) disable iff (reset)
      rel_ff <= held_ff)
      else $error("released count above held count");

   a_ins_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tneq_pkg::ST_INS_READ || state_ff == tneq_pkg::ST_INS_EVAL)
      |-> (at_ff >= rel_ff && at_ff <= held_ff && held_ff < CW'(tneq_pkg::QUEUE_DEPTH)))
      else $error("insert slot outside pending range");

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !emit)
      else $error("result produced over an untaken transfer");

endmodule

### bench/timestamped_note_event_queue_tb.sv
module timestamped_note_event_queue_tb;

   localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
   localparam logic [3:0] STATUS_SYSTEM   = 4'hf;
   localparam logic [7:0] CC_RESET_CTRL   = 8'd121;
   localparam int RANDOM_ITEMS  = 105;
   localparam int QUIET_TAIL    = 20;
   localparam int PRESSURE_AT   = 30;
   localparam int PRESSURE_LEN  = 600;
   localparam int DRAIN_CYCLES  = 300;
   localparam int CYCLE_LIMIT   = 2000000;

   typedef struct {
      tneq_pkg::kind_type kind;
      logic [7:0]         status_byte;
      logic [7:0]         data_one;
      logic [7:0]         data_two;
      logic [1:0]         msg_length;
      logic signed [15:0] event_offset;
      logic [12:0]        frame_value;
   } req_item_type;

   typedef struct {
      tneq_pkg::report_type report;
      logic                 is_panic;
      logic [2:0]           voice;
      logic [6:0]           velocity;
      logic [6:0]           queue_count;
      logic                 last;
   } trigger_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tneq_req_if req_bus ();
   tneq_rsp_if rsp_bus ();

   timestamped_note_event_queue i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   req_item_type       midi_stream [$];
   trigger_result_type expected_triggers [$];
   req_item_type       cur_item;

   logic [14:0] shadow_offset [tneq_pkg::QUEUE_DEPTH];
   logic [3:0]  shadow_code   [tneq_pkg::QUEUE_DEPTH];
   logic [6:0]  shadow_vel    [tneq_pkg::QUEUE_DEPTH];
   int          shadow_held = 0;
   int          shadow_released = 0;

   int   mismatches = 0;
   int   cycle_count = 0;
   int   accepted_items = 0;
   int   req_gap = 0;
   int   rsp_gap = 0;
   int   hold_left = 0;
   logic pressure_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic req_item_type midi_item(input logic [7:0] status, input logic [7:0] d1,
                                              input logic [7:0] d2, input logic [1:0] len,
                                              input logic signed [15:0] ofs);
      req_item_type it;
      it.kind         = tneq_pkg::KIND_MIDI;
      it.status_byte  = status;
      it.data_one     = d1;
      it.data_two     = d2;
      it.msg_length   = len;
      it.event_offset = ofs;
      it.frame_value  = 13'($urandom);
      return it;
   endfunction

   function automatic req_item_type frame_item(input tneq_pkg::kind_type k,
                                               input logic [12:0] fv);
      req_item_type it;
      it.kind         = k;
      it.status_byte  = 8'($urandom);
      it.data_one     = 8'($urandom);
      it.data_two     = 8'($urandom);
      it.msg_length   = 2'($urandom);
      it.event_offset = 16'($urandom);
      it.frame_value  = fv;
      return it;
   endfunction

   function automatic req_item_type random_note(input logic signed [15:0] ofs);
      return midi_item({tneq_pkg::STATUS_NOTE_ON, 4'($urandom)},
                       tneq_pkg::DRUM_NOTES[$urandom_range(0, tneq_pkg::NUM_VOICES - 1)],
                       8'($urandom_range(1, 127)), tneq_pkg::FULL_LENGTH, ofs);
   endfunction

   function automatic req_item_type random_panic(input logic signed [15:0] ofs);
      return midi_item({tneq_pkg::STATUS_CONTROL, 4'($urandom)},
                       $urandom_range(0, 1) ? tneq_pkg::CC_ALL_SOUND_OFF
                                            : tneq_pkg::CC_ALL_NOTES_OFF,
                       8'($urandom), tneq_pkg::FULL_LENGTH, ofs);
   endfunction

   function automatic void push_trigger(input tneq_pkg::report_type r, input logic p,
                                        input logic [2:0] v, input logic [6:0] vel,
                                        input logic l);
      trigger_result_type t;
      t.report      = r;
      t.is_panic    = p;
      t.voice       = v;
      t.velocity    = vel;
      t.queue_count = 7'(shadow_held - shadow_released);
      t.last        = l;
      expected_triggers.push_back(t);
   endfunction

   // sorted insert, stable for equal offsets, never ahead of released entries
   function automatic void store_entry(input logic [14:0] ofs, input logic [3:0] code,
                                       input logic [6:0] vel);
      int at;
      at = shadow_held;
      while (at > shadow_released && at > 0 && shadow_offset[at - 1] > ofs) begin
         shadow_offset[at] = shadow_offset[at - 1];
         shadow_code[at]   = shadow_code[at - 1];
         shadow_vel[at]    = shadow_vel[at - 1];
         at--;
      end
      shadow_offset[at] = ofs;
      shadow_code[at]   = code;
      shadow_vel[at]    = vel;
      shadow_held++;
   endfunction

   task automatic predict_triggers(input req_item_type it);
      logic [3:0]  nib;
      logic [14:0] ofs;
      logic [14:0] o;
      logic [3:0]  code;
      logic        panic;
      logic        found;
      logic        more;
      logic [2:0]  v;
      int          frames;
      int          j;
      case (it.kind)
         tneq_pkg::KIND_MIDI: begin
            nib   = it.status_byte[7:4];
            ofs   = it.event_offset[15] ? 15'd0 : it.event_offset[14:0];
            panic = 1'b0;
            found = 1'b0;
            v     = '0;
            if (it.msg_length == tneq_pkg::FULL_LENGTH && nib == tneq_pkg::STATUS_CONTROL &&
                (it.data_one == tneq_pkg::CC_ALL_SOUND_OFF ||
                 it.data_one == tneq_pkg::CC_ALL_NOTES_OFF)) begin
               panic = 1'b1;
            end else if (it.msg_length == tneq_pkg::FULL_LENGTH &&
                         nib == tneq_pkg::STATUS_NOTE_ON &&
                         it.data_two >= 8'd1 && it.data_two <= 8'd127) begin
               for (int i = 0; i < tneq_pkg::NUM_VOICES; i++) begin
                  if (!found && it.data_one == tneq_pkg::DRUM_NOTES[i]) begin
                     found = 1'b1;
                     v     = 3'(i);
                  end
               end
            end
            if (!panic && !found) begin
               push_trigger(tneq_pkg::RPT_IGNORED, 1'b0, '0, '0, 1'b1);
            end else if (shadow_held >= tneq_pkg::QUEUE_DEPTH && !panic) begin
               push_trigger(tneq_pkg::RPT_DROPPED, 1'b0, '0, '0, 1'b1);
            end else if (shadow_held >= tneq_pkg::QUEUE_DEPTH) begin
               shadow_held     = 0;
               shadow_released = 0;
               store_entry(ofs, tneq_pkg::PANIC_CODE, '0);
               push_trigger(tneq_pkg::RPT_FLUSHED, 1'b1, '0, '0, 1'b1);
            end else if (panic) begin
               store_entry(ofs, tneq_pkg::PANIC_CODE, '0);
               push_trigger(tneq_pkg::RPT_QUEUED, 1'b1, '0, '0, 1'b1);
            end else begin
               store_entry(ofs, {1'b0, v}, it.data_two[6:0]);
               push_trigger(tneq_pkg::RPT_QUEUED, 1'b0, v, it.data_two[6:0], 1'b1);
            end
         end
         tneq_pkg::KIND_TICK: begin
            more = shadow_released < shadow_held &&
                   int'(shadow_offset[shadow_released]) <= int'(it.frame_value);
            if (!more) begin
               push_trigger(tneq_pkg::RPT_DONE, 1'b0, '0, '0, 1'b1);
            end
            while (more) begin
               code = shadow_code[shadow_released];
               shadow_released++;
               more = shadow_released < shadow_held &&
                      int'(shadow_offset[shadow_released]) <= int'(it.frame_value);
               if (code >= tneq_pkg::PANIC_CODE) begin
                  push_trigger(tneq_pkg::RPT_RELEASED, 1'b1, '0, '0, !more);
               end else begin
                  push_trigger(tneq_pkg::RPT_RELEASED, 1'b0, code[2:0],
                               shadow_vel[shadow_released - 1], !more);
               end
            end
         end
         tneq_pkg::KIND_BLOCK: begin
            frames = int'(it.frame_value);
            if (frames != 0) begin
               if (frames > tneq_pkg::MAX_BLOCK) begin
                  frames = tneq_pkg::MAX_BLOCK;
               end
               j = 0;
               for (int i = shadow_released; i < shadow_held; i++) begin
                  o = shadow_offset[i];
                  shadow_offset[j] = (int'(o) > frames) ? 15'(int'(o) - frames) : 15'd0;
                  shadow_code[j]   = shadow_code[i];
                  shadow_vel[j]    = shadow_vel[i];
                  j++;
               end
               shadow_held     = j;
               shadow_released = 0;
            end
            push_trigger(tneq_pkg::RPT_DONE, 1'b0, '0, '0, 1'b1);
         end
         default: begin
            shadow_held     = 0;
            shadow_released = 0;
            push_trigger(tneq_pkg::RPT_DONE, 1'b0, '0, '0, 1'b1);
         end
      endcase
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid  <= 1'b0;
         accepted_items <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_triggers(cur_item);
            accepted_items <= accepted_items + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (midi_stream.size() != 0) begin
               cur_item = midi_stream.pop_front();
               req_bus.kind         <= cur_item.kind;
               req_bus.status_byte  <= cur_item.status_byte;
               req_bus.data_one     <= cur_item.data_one;
               req_bus.data_two     <= cur_item.data_two;
               req_bus.msg_length   <= cur_item.msg_length;
               req_bus.event_offset <= cur_item.event_offset;
               req_bus.frame_value  <= cur_item.frame_value;
               req_bus.valid        <= 1'b1;
               if (midi_stream.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                  req_gap = $urandom_range(1, 18);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the input stalls
   always @(posedge clock) begin
      if (reset) begin
         hold_left     <= 0;
         pressure_done <= 1'b0;
      end else if (!pressure_done && accepted_items >= PRESSURE_AT) begin
         hold_left     <= PRESSURE_LEN;
         pressure_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin : rsp_monitor
      trigger_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_triggers.size() == 0) begin
               $display("%0t: unexpected transfer, expected none actual report %0d",
                        $time, rsp_bus.report);
               mismatches++;
            end else begin
               want = expected_triggers.pop_front();
               compare_field("report", int'(want.report), int'(rsp_bus.report));
               compare_field("is_panic", int'(want.is_panic), int'(rsp_bus.is_panic));
               compare_field("voice", int'(want.voice), int'(rsp_bus.voice));
               compare_field("velocity", int'(want.velocity), int'(rsp_bus.velocity));
               compare_field("queue_count", int'(want.queue_count), int'(rsp_bus.queue_count));
               compare_field("last", int'(want.last), int'(rsp_bus.last));
            end
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (midi_stream.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
               rsp_gap = $urandom_range(1, 18);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic signed [15:0] ofs;
      int block_len;
      int notes;
      int frame_pos;
      int random_start;

      req_bus.valid        = 1'b0;
      req_bus.kind         = tneq_pkg::KIND_MIDI;
      req_bus.status_byte  = '0;
      req_bus.data_one     = '0;
      req_bus.data_two     = '0;
      req_bus.msg_length   = '0;
      req_bus.event_offset = '0;
      req_bus.frame_value  = '0;
      rsp_bus.ready        = 1'b0;

      // every voice, velocity and offset extremes, negative offset clamps
      for (int v = 0; v < tneq_pkg::NUM_VOICES; v++) begin
         if (v == 0) begin
            ofs = 16'sh8000;
         end else if (v == 1) begin
            ofs = 16'sh7fff;
         end else begin
            ofs = 16'(v * 10);
         end
         midi_stream.push_back(midi_item({tneq_pkg::STATUS_NOTE_ON, 4'(v)},
                                         tneq_pkg::DRUM_NOTES[v], v[0] ? 8'd127 : 8'd1,
                                         tneq_pkg::FULL_LENGTH, ofs));
      end
      midi_stream.push_back(midi_item({tneq_pkg::STATUS_CONTROL, 4'hf},
                                      tneq_pkg::CC_ALL_SOUND_OFF, 8'd0,
                                      tneq_pkg::FULL_LENGTH, 16'sd5));
      midi_stream.push_back(midi_item({tneq_pkg::STATUS_CONTROL, 4'h0},
                                      tneq_pkg::CC_ALL_NOTES_OFF, 8'hff,
                                      tneq_pkg::FULL_LENGTH, -16'sd1));
      // ignored messages
      midi_stream.push_back(midi_item({tneq_pkg::STATUS_NOTE_ON, 4'h0},
                                      tneq_pkg::DRUM_NOTES[0], 8'd100, 2'd2, 16'sd0));
      midi_stream.push_back(midi_item({tneq_pkg::STATUS_NOTE_ON, 4'h0},
                                      tneq_pkg::DRUM_NOTES[1], 8'd100, 2'd0, 16'sd0));
      midi_stream.push_back(midi_item({tneq_pkg::STATUS_NOTE_ON, 4'h3},
                                      tneq_pkg::DRUM_NOTES[2], 8'd0,
                                      tneq_pkg::FULL_LENGTH, 16'sd0));
      midi_stream.push_back(midi_item({tneq_pkg::STATUS_NOTE_ON, 4'h3}, 8'd40, 8'd64,
                                      tneq_pkg::FULL_LENGTH, 16'sd0));
      midi_stream.push_back(midi_item({STATUS_NOTE_OFF, 4'h0}, tneq_pkg::DRUM_NOTES[3], 8'd64,
                                      tneq_pkg::FULL_LENGTH, 16'sd0));
      midi_stream.push_back(midi_item({tneq_pkg::STATUS_CONTROL, 4'h0}, CC_RESET_CTRL, 8'd0,
                                      tneq_pkg::FULL_LENGTH, 16'sd0));
      midi_stream.push_back(midi_item({STATUS_SYSTEM, 4'h0}, tneq_pkg::CC_ALL_SOUND_OFF, 8'd0,
                                      tneq_pkg::FULL_LENGTH, 16'sd0));
      // tick, note between ticks, nothing due, release all reachable, then block ends and a clear
      midi_stream.push_back(frame_item(tneq_pkg::KIND_TICK, 13'd0));
      midi_stream.push_back(midi_item({tneq_pkg::STATUS_NOTE_ON, 4'h0},
                                      tneq_pkg::DRUM_NOTES[7], 8'd77,
                                      tneq_pkg::FULL_LENGTH, 16'sd0));
      midi_stream.push_back(frame_item(tneq_pkg::KIND_TICK, 13'd0));
      midi_stream.push_back(frame_item(tneq_pkg::KIND_TICK, 13'd0));
      midi_stream.push_back(frame_item(tneq_pkg::KIND_TICK, 13'h1fff));
      midi_stream.push_back(frame_item(tneq_pkg::KIND_BLOCK, 13'd0));
      midi_stream.push_back(frame_item(tneq_pkg::KIND_BLOCK, 13'h1fff));
      midi_stream.push_back(frame_item(tneq_pkg::KIND_CLEAR, 13'd0));

      random_start = midi_stream.size();

      // fill to depth, drop, release some, drop again, then panic flush
      midi_stream.push_back(frame_item(tneq_pkg::KIND_CLEAR, 13'($urandom)));
      for (int i = 0; i < tneq_pkg::QUEUE_DEPTH; i++) begin
         midi_stream.push_back(random_note(16'($urandom_range(0, 3000))));
      end
      midi_stream.push_back(random_note(16'($urandom_range(0, 3000))));
      midi_stream.push_back(frame_item(tneq_pkg::KIND_TICK, 13'($urandom_range(0, 1500))));
      midi_stream.push_back(random_note(16'($urandom_range(0, 3000))));
      midi_stream.push_back(random_panic(16'($urandom_range(0, 3000))));
      midi_stream.push_back(frame_item(tneq_pkg::KIND_TICK, 13'($urandom_range(0, 4000))));
      midi_stream.push_back(frame_item(tneq_pkg::KIND_BLOCK, 13'($urandom_range(1, 4096))));

      while (midi_stream.size() - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            midi_stream.push_back(frame_item(tneq_pkg::kind_type'($urandom_range(0, 3)),
                                             13'($urandom)));
            midi_stream[$].status_byte  = 8'($urandom);
            midi_stream[$].msg_length   = 2'($urandom);
            midi_stream[$].event_offset = 16'($urandom);
         end else begin
            if ($urandom_range(0, 9) == 0) begin
               block_len = $urandom_range(tneq_pkg::MAX_BLOCK + 1, 8191);
            end else if ($urandom_range(0, 15) == 0) begin
               block_len = 0;
            end else begin
               block_len = $urandom_range(1, 600);
            end
            notes     = $urandom_range(1, 6);
            frame_pos = 0;
            for (int i = 0; i < notes; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  ofs = {1'b1, 15'($urandom)};
               end else begin
                  ofs = 16'($urandom_range(0, block_len));
               end
               if ($urandom_range(0, 7) == 0) begin
                  midi_stream.push_back(random_panic(ofs));
               end else begin
                  midi_stream.push_back(random_note(ofs));
               end
               if ($urandom_range(0, 2) == 0) begin
                  frame_pos = frame_pos + $urandom_range(0, 100);
                  if (frame_pos > 8191) begin
                     frame_pos = 8191;
                  end
                  midi_stream.push_back(frame_item(tneq_pkg::KIND_TICK, 13'(frame_pos)));
               end
            end
            midi_stream.push_back(frame_item(tneq_pkg::KIND_TICK, 13'(block_len)));
            midi_stream.push_back(frame_item(tneq_pkg::KIND_BLOCK, 13'(block_len)));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (midi_stream.size() != 0 || req_bus.valid || expected_triggers.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_triggers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
